// ===== hw/rtl/pcs_pkg.sv =====
// Package for the path component splitter: item, state and result types,
// character codes and the per-byte parsing functions.
// No dependencies; used by pcs_core and path_component_splitter_unit.
package pcs_pkg;

    localparam int MAX_PATH_BYTES_DEF = 65535;
    localparam int OFS_W = 16;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    typedef logic [OFS_W-1:0] ofs_t;

    typedef enum logic [3:0] {
        PH_START,
        PH_WAIT2,
        PH_ROOT_SEP,
        PH_SRV_SEP,
        PH_SRV_NAME,
        PH_GAP,
        PH_DOTS,
        PH_NAME,
        PH_ENDED
    } pcs_phase_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       has_byte;
        logic       last;
    } pcs_item_t;

    typedef struct packed {
        pcs_phase_t phase;
        ofs_t       position;
        logic [7:0] first_byte;
        ofs_t       root_ofs;
        ofs_t       dir_ofs;
        ofs_t       base_ofs;
        ofs_t       ext_ofs;
        ofs_t       name_ofs;
        logic       last_was_sep;
        logic       overflow;
    } pcs_state_t;

    typedef struct packed {
        ofs_t root_end;
        ofs_t dir_end;
        ofs_t base_start;
        ofs_t ext_start;
        ofs_t name_end;
        logic need_separator;
        logic too_long;
    } pcs_result_t;

    function automatic pcs_state_t pcs_clear();
        pcs_state_t st;
        st = '0;
        st.phase = PH_START;
        return st;
    endfunction

    function automatic logic is_sep(input logic [7:0] c, input logic win);
        return (c == CH_SLASH) || (win && (c == CH_BSLASH));
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
               ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
    endfunction

    // Close the current component at offset end_ofs.
    function automatic pcs_state_t finish_comp(input pcs_state_t st_in, input ofs_t end_ofs);
        pcs_state_t st;
        st = st_in;
        if ((st.ext_ofs == st.base_ofs) || (ofs_t'(end_ofs - st.ext_ofs) < ofs_t'(2))) begin
            st.ext_ofs = end_ofs;
        end
        st.name_ofs = end_ofs;
        st.phase = PH_GAP;
        return st;
    endfunction

    function automatic pcs_state_t enter_body(input pcs_state_t st_in);
        pcs_state_t st;
        st = st_in;
        st.dir_ofs  = st.root_ofs;
        st.ext_ofs  = st.root_ofs;
        st.name_ofs = st.root_ofs;
        st.phase    = PH_GAP;
        return st;
    endfunction

    // One byte through every phase past the drive/server probe.
    function automatic pcs_state_t feed_body(input pcs_state_t st_in, input logic [7:0] c,
                                             input ofs_t i, input logic win);
        pcs_state_t st;
        logic       s;
        st = st_in;
        s  = is_sep(c, win);
        case (st.phase)
            PH_ROOT_SEP: begin
                if (s) begin
                    st.root_ofs = ofs_t'(i + ofs_t'(1));
                end else begin
                    // first body byte: open the first component right away
                    st = enter_body(st);
                    st.dir_ofs  = st.name_ofs;
                    st.base_ofs = i;
                    st.ext_ofs  = i;
                    st.phase    = (c == CH_DOT) ? PH_DOTS : PH_NAME;
                end
            end
            PH_SRV_SEP: begin
                st.root_ofs = ofs_t'(i + ofs_t'(1));
                if (!s) st.phase = PH_SRV_NAME;
            end
            PH_SRV_NAME: begin
                st.root_ofs = ofs_t'(i + ofs_t'(1));
                if (s) st = enter_body(st);
            end
            PH_GAP: begin
                if (!s) begin
                    st.dir_ofs  = st.name_ofs;
                    st.base_ofs = i;
                    st.ext_ofs  = i;
                    st.phase    = (c == CH_DOT) ? PH_DOTS : PH_NAME;
                end
            end
            PH_DOTS: begin
                if (s) st = finish_comp(st, i);
                else if (c != CH_DOT) st.phase = PH_NAME;
            end
            PH_NAME: begin
                if (s) st = finish_comp(st, i);
                else if (c == CH_DOT) st.ext_ofs = i;
            end
            default: begin
            end
        endcase
        return st;
    endfunction

    function automatic pcs_state_t feed_top(input pcs_state_t st_in, input logic [7:0] c,
                                            input ofs_t i, input logic win);
        pcs_state_t st;
        logic       s;
        st = st_in;
        s  = is_sep(c, win);
        case (st.phase)
            PH_START: begin
                if (win) begin
                    st.first_byte = c;
                    st.phase = PH_WAIT2;
                end else begin
                    st.phase = PH_ROOT_SEP;
                    st = feed_body(st, c, i, win);
                end
            end
            PH_WAIT2: begin
                if (is_sep(st.first_byte, win) && s) begin
                    st.root_ofs = ofs_t'(2);
                    st.phase = PH_SRV_SEP;
                end else if (is_alpha(st.first_byte) && (c == CH_COLON)) begin
                    st.root_ofs = ofs_t'(2);
                    st.phase = PH_ROOT_SEP;
                end else begin
                    // no prefix: replay the held first byte, then this one
                    st.phase = PH_ROOT_SEP;
                    st = feed_body(st, st.first_byte, '0, win);
                    st = feed_body(st, c, i, win);
                end
            end
            default: st = feed_body(st, c, i, win);
        endcase
        return st;
    endfunction

    function automatic pcs_state_t close_path(input pcs_state_t st_in, input logic win);
        pcs_state_t st;
        st = st_in;
        if (st.phase != PH_ENDED) begin
            if (st.phase == PH_WAIT2) begin
                st.phase = PH_ROOT_SEP;
                st = feed_body(st, st.first_byte, '0, win);
            end
            if ((st.phase == PH_START) || (st.phase == PH_ROOT_SEP) ||
                (st.phase == PH_SRV_SEP) || (st.phase == PH_SRV_NAME)) begin
                st = enter_body(st);
                st.base_ofs = '0;
            end else if ((st.phase == PH_DOTS) || (st.phase == PH_NAME)) begin
                st = finish_comp(st, st.position);
            end
            st.phase = PH_ENDED;
        end
        return st;
    endfunction

endpackage

// ===== hw/rtl/pcs_core.sv =====
// Path parsing core: holds the per-path state, updated one word per cycle
// when item_fire is set; builds the result on the last word. Uses pcs_pkg.
module pcs_core #(
    parameter int MAX_PATH_BYTES = pcs_pkg::MAX_PATH_BYTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                windows_mode,
    input  logic                item_fire,
    input  pcs_pkg::pcs_item_t  item,
    output pcs_pkg::pcs_result_t result
);
    import pcs_pkg::*;

    localparam ofs_t MaxPos = ofs_t'(MAX_PATH_BYTES);

    pcs_state_t state_reg;
    pcs_state_t state_next;
    ofs_t       cur_pos;

    always_comb begin
        state_next = state_reg;
        result     = '0;
        cur_pos    = state_reg.position;
        if (item_fire) begin
            if (item.has_byte && (state_reg.phase != PH_ENDED)) begin
                if (state_reg.position >= MaxPos) begin
                    state_next.overflow = 1'b1;
                end else if (item.byte_value == CH_NUL) begin
                    state_next = close_path(state_next, windows_mode);
                end else begin
                    state_next.position     = ofs_t'(cur_pos + ofs_t'(1));
                    state_next.last_was_sep = is_sep(item.byte_value, windows_mode);
                    state_next = feed_top(state_next, item.byte_value, cur_pos, windows_mode);
                end
            end
            if (item.last) begin
                state_next = close_path(state_next, windows_mode);
                result.root_end   = state_next.root_ofs;
                result.dir_end    = state_next.dir_ofs;
                result.base_start = state_next.base_ofs;
                result.ext_start  = state_next.ext_ofs;
                result.name_end   = state_next.name_ofs;
                result.too_long   = state_next.overflow;
                if (state_next.position == '0) begin
                    result.need_separator = 1'b1;
                end else begin
                    result.need_separator = !((state_next.root_ofs == state_next.position) ||
                                              state_next.last_was_sep);
                end
                state_next = pcs_clear();
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pcs_clear();
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        item_fire && item.last |=> (state_reg.position == '0) && (state_reg.phase == PH_START))
        else $error("path state not cleared after last word");

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.position <= MaxPos)
        else $error("position beyond path limit");

    a_root_le_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.root_ofs <= state_reg.position)
        else $error("root end beyond bytes seen");

    a_gap_order: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase == PH_GAP |->
            (state_reg.ext_ofs <= state_reg.name_ofs) && (state_reg.dir_ofs <= state_reg.name_ofs))
        else $error("component offsets out of order");
`endif

endmodule

// ===== hw/rtl/path_component_splitter_unit.sv =====
// Top level of the path component splitter: input register, parsing core
// and result register. Depends on pcs_pkg and pcs_core.
//
// Feed a path one word per cycle (one byte, has_byte, last) and collect one
// result word per path, given on the word marked last: root_end, dir_end,
// base_start, ext_start, name_end, need_separator and too_long. The block
// accepts a new word in every cycle unless a last word is held waiting for
// the result slot; a word enters an input register, is parsed by the core
// from there, and a last word's result lands in the output register. A word
// that is not last never waits on the output side; a last word waits only
// while an earlier result is still held. The byte rate is set by the
// per-byte state update in pcs_core, a handful of compares and 16-bit
// offset moves. Bytes past MAX_PATH_BYTES are dropped and flagged with
// too_long; a NUL byte ends the path early.
// windows_mode (cfg_wr_en/cfg_wr_data) adds backslash as a separator plus
// drive-letter and server-prefix roots; write it only while no path is open.
module path_component_splitter_unit #(
    parameter int MAX_PATH_BYTES = pcs_pkg::MAX_PATH_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_byte_value,
    input  logic                 s_has_byte,
    input  logic                 s_last,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [15:0]          m_root_end,
    output logic [15:0]          m_dir_end,
    output logic [15:0]          m_base_start,
    output logic [15:0]          m_ext_start,
    output logic [15:0]          m_name_end,
    output logic                 m_need_separator,
    output logic                 m_too_long
);
    import pcs_pkg::*;

    logic        win_mode_reg;
    logic        in_valid_reg;
    pcs_item_t   in_item_reg;
    logic        m_valid_reg;
    pcs_result_t result_reg;

    logic        out_free;
    logic        core_fire;
    pcs_result_t core_result;

    // Configuration: one bit, written straight through.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            win_mode_reg <= cfg_wr_data;
        end
    end

    // Output slot is free when empty or being drained this cycle.
    assign out_free  = !m_valid_reg || m_ready;
    // Advance the held word unless it is last and the result slot is busy.
    assign core_fire = in_valid_reg && (!in_item_reg.last || out_free);
    // Take a new word whenever the input register empties this cycle.
    assign s_ready   = !in_valid_reg || core_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.byte_value <= s_byte_value;
            in_item_reg.has_byte   <= s_has_byte;
            in_item_reg.last       <= s_last;
        end
    end

    pcs_core #(
        .MAX_PATH_BYTES (MAX_PATH_BYTES)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .windows_mode (win_mode_reg),
        .item_fire    (core_fire),
        .item         (in_item_reg),
        .result       (core_result)
    );

    // Result register: load on a fired last word, drop on acceptance.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (core_fire && in_item_reg.last) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (core_fire && in_item_reg.last) begin
            result_reg <= core_result;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_root_end       = result_reg.root_end;
    assign m_dir_end        = result_reg.dir_end;
    assign m_base_start     = result_reg.base_start;
    assign m_ext_start      = result_reg.ext_start;
    assign m_name_end       = result_reg.name_end;
    assign m_need_separator = result_reg.need_separator;
    assign m_too_long       = result_reg.too_long;

endmodule
